FILE: rtl/core/ialu_pkg.sv
package ialu_pkg;

   localparam int unsigned DataWidthDefault = 64;

   typedef enum logic [4:0] {
      OP_ADD  = 5'd0,
      OP_SUB  = 5'd1,
      OP_MUL  = 5'd2,
      OP_DIVS = 5'd3,
      OP_DIVU = 5'd4,
      OP_MODS = 5'd5,
      OP_MODU = 5'd6,
      OP_AND  = 5'd7,
      OP_OR   = 5'd8,
      OP_XOR  = 5'd9,
      OP_SHL  = 5'd10,
      OP_SHRL = 5'd11,
      OP_SHRA = 5'd12,
      OP_EQ   = 5'd13,
      OP_NE   = 5'd14,
      OP_LTS  = 5'd15,
      OP_GTS  = 5'd16,
      OP_LES  = 5'd17,
      OP_GES  = 5'd18,
      OP_LTU  = 5'd19,
      OP_GTU  = 5'd20,
      OP_LEU  = 5'd21,
      OP_GEU  = 5'd22
   } op_type;

   typedef struct packed {
      logic [4:0]  action;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [63:0] result;
      logic        status;
   } rsp_type;

   // control that travels alongside the divider stages
   typedef struct packed {
      logic       is_div;
      logic       neg_q;
      logic       neg_r;
      logic       want_rem;
      logic       div_zero;
   } div_ctl_type;

endpackage

FILE: rtl/core/integer_alu_64.sv
// integer_alu_64: pipelined 64-bit integer execute unit
// request channel: drive req_data with start high; a beat is taken at any
// edge where start is high and busy is low. busy is tied low: a new beat
// can enter on every cycle
// response channel: rsp_strobe marks a beat on rsp_data for exactly one
// cycle; the receiver cannot hold it off, there is no back pressure
// ordering: every operation takes the same path length from the accepting
// edge to the edge that takes the result, so results leave in request order.
// the radix-2 divider chain (one quotient bit per stage) sets the pipeline depth;
// the other operations ride a delay line of equal length
// stage 1 registers operands, decodes, forms magnitudes for signed divide
// stage 2..W+1 divide steps; a 32x32 partial product multiplier also works
// across the first stages of the delay line
// last stage picks the result and applies sign and zero-divisor rules
// throughput: one beat per cycle
// reset: synchronous, clears all valid bits; data registers are not reset
module integer_alu_64 import ialu_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int unsigned W     = DATA_WIDTH;
   localparam int unsigned Depth = W;       // stages after the decode stage
   localparam int unsigned HW    = (W + 1) / 2;

   assign busy = 1'b0;

   // ---------------- stage 1: decode ----------------
   logic [W-1:0] a_ff, b_ff;
   logic [4:0]   op_ff;
   logic         v1_ff;
   logic [5:0]   sh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      a_ff  <= req_data.operand_a[W-1:0];
      b_ff  <= req_data.operand_b[W-1:0];
      op_ff <= req_data.action;
      sh_ff <= req_data.operand_b[5:0];
   end

   // simple result, computed in stage 2 and delayed
   logic [W-1:0] simple_in;
   logic         sa_neg, sb_neg;
   logic         lts, ltu, is_signed_div;
   logic [W-1:0] mag_a, mag_b, div_a, div_b;
   div_ctl_type  dctl_in;

   assign sa_neg = a_ff[W-1];
   assign sb_neg = b_ff[W-1];
   assign ltu    = a_ff < b_ff;
   assign lts    = (sa_neg != sb_neg) ? sa_neg : ltu;
   assign mag_a  = sa_neg ? (~a_ff + 1'b1) : a_ff;
   assign mag_b  = sb_neg ? (~b_ff + 1'b1) : b_ff;
   assign is_signed_div = (op_ff == OP_DIVS) || (op_ff == OP_MODS);
   assign div_a  = is_signed_div ? mag_a : a_ff;
   assign div_b  = is_signed_div ? mag_b : b_ff;

   always_comb begin
      dctl_in.is_div   = (op_ff == OP_DIVS) || (op_ff == OP_DIVU) ||
                         (op_ff == OP_MODS) || (op_ff == OP_MODU);
      dctl_in.neg_q    = is_signed_div && (sa_neg != sb_neg);
      dctl_in.neg_r    = is_signed_div && sa_neg;
      dctl_in.want_rem = (op_ff == OP_MODS) || (op_ff == OP_MODU);
      dctl_in.div_zero = (b_ff == '0);
   end

   always_comb begin
      logic big;
      big = ({26'd0, sh_ff} >= 32'(W));
      simple_in = '0;
      unique case (op_ff)
         OP_ADD:  simple_in = a_ff + b_ff;
         OP_SUB:  simple_in = a_ff - b_ff;
         OP_AND:  simple_in = a_ff & b_ff;
         OP_OR:   simple_in = a_ff | b_ff;
         OP_XOR:  simple_in = a_ff ^ b_ff;
         OP_SHL:  simple_in = big ? '0 : (a_ff << sh_ff);
         OP_SHRL: simple_in = big ? '0 : (a_ff >> sh_ff);
         OP_SHRA: simple_in = big ? {W{sa_neg}} : W'($signed(a_ff) >>> sh_ff);
         OP_EQ:   simple_in = W'(a_ff == b_ff);
         OP_NE:   simple_in = W'(a_ff != b_ff);
         OP_LTS:  simple_in = W'(lts);
         OP_GTS:  simple_in = W'(!lts && (a_ff != b_ff));
         OP_LES:  simple_in = W'(lts || (a_ff == b_ff));
         OP_GES:  simple_in = W'(!lts);
         OP_LTU:  simple_in = W'(ltu);
         OP_GTU:  simple_in = W'(!ltu && (a_ff != b_ff));
         OP_LEU:  simple_in = W'(ltu || (a_ff == b_ff));
         OP_GEU:  simple_in = W'(!ltu);
         default: simple_in = '0;
      endcase
   end

   // multiplier: 3 partial products over stages
   logic [HW-1:0] al, ah, bl, bh;
   assign al = HW'(a_ff);
   assign ah = HW'(a_ff >> HW);
   assign bl = HW'(b_ff);
   assign bh = HW'(b_ff >> HW);

   logic [2*HW-1:0] pll_ff, plh_ff, phl_ff;
   logic [W-1:0]    prod_ff;

   always_ff @(posedge clock) begin
      pll_ff <= al * bl;
      plh_ff <= al * bh;
      phl_ff <= ah * bl;
   end

   logic [W-1:0] prod_in;
   assign prod_in = W'(pll_ff) + W'({plh_ff, {HW{1'b0}}}) + W'({phl_ff, {HW{1'b0}}});

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // ---------------- delay line for control and simple results ----------------
   logic [W-1:0] simp_ff [Depth];
   logic [4:0]   opd_ff  [Depth];
   div_ctl_type  dctl_ff [Depth];
   logic [W-1:0] mul_ff  [Depth];
   logic         v_ff    [Depth];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Depth; i++) v_ff[i] <= 1'b0;
      end else begin
         v_ff[0] <= v1_ff;
         for (int i = 1; i < Depth; i++) v_ff[i] <= v_ff[i-1];
      end
      simp_ff[0] <= simple_in;
      opd_ff[0]  <= op_ff;
      dctl_ff[0] <= dctl_in;
      mul_ff[0]  <= '0;
      for (int i = 1; i < Depth; i++) begin
         simp_ff[i] <= simp_ff[i-1];
         opd_ff[i]  <= opd_ff[i-1];
         dctl_ff[i] <= dctl_ff[i-1];
         // product becomes available two stages after decode
         mul_ff[i]  <= (i == 2) ? prod_ff : mul_ff[i-1];
      end
   end

   // ---------------- divider ----------------
   logic [W-1:0] quo, rem;

   ialu_divider #(
      .DATA_WIDTH(W)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v1_ff && dctl_in.is_div),
      .in_dividend  (div_a),
      .in_divisor   (div_b),
      .out_quotient (quo),
      .out_remainder(rem)
   );

   // ---------------- output stage ----------------
   div_ctl_type  dc;
   logic [W-1:0] dv, res_in;
   logic         st_in;

   assign dc = dctl_ff[Depth-1];
   assign dv = dc.want_rem ? (dc.neg_r ? (~rem + 1'b1) : rem)
                           : (dc.neg_q ? (~quo + 1'b1) : quo);

   always_comb begin
      st_in = 1'b0;
      if (dc.is_div) begin
         st_in  = dc.div_zero;
         res_in = dc.div_zero ? '0 : dv;
      end else if (opd_ff[Depth-1] == OP_MUL) begin
         res_in = mul_ff[Depth-1];
      end else begin
         res_in = simp_ff[Depth-1];
      end
   end

   logic         strobe_ff;
   logic [W-1:0] res_ff;
   logic         st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= v_ff[Depth-1];
      end
      res_ff <= res_in;
      st_ff  <= st_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_data.result = 64'(res_ff);
   assign rsp_data.status = st_ff;

`ifndef SYNTHESIS
   // a response appears exactly the pipeline depth after its request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(W + 2) rsp_strobe)
      else $error("response missing after request");

   // no response without a request in flight
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(v_ff[Depth-1]))
      else $error("spurious response");

   // error status only with a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.status) |-> (rsp_data.result == '0))
      else $error("error response carries data");
`endif

endmodule

FILE: rtl/core/ialu_divider.sv
module ialu_divider import ialu_pkg::*; #(
   parameter int unsigned DATA_WIDTH = DataWidthDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic [DATA_WIDTH-1:0] in_dividend,
   input  logic [DATA_WIDTH-1:0] in_divisor,
   output logic [DATA_WIDTH-1:0] out_quotient,
   output logic [DATA_WIDTH-1:0] out_remainder
);

   // one radix-2 restoring step per stage, fully pipelined
   localparam int unsigned W = DATA_WIDTH;

   logic [W-1:0] rem_ff [W+1];
   logic [W-1:0] quo_ff [W+1];
   logic [W-1:0] dvs_ff [W+1];
   logic         vld_ff [W+1];

   always_comb begin
      rem_ff[0] = '0;
      quo_ff[0] = in_dividend;
      dvs_ff[0] = in_divisor;
      vld_ff[0] = in_valid;
   end

   for (genvar s = 0; s < W; s++) begin : g_step
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic [W-1:0] rem_in;
      logic [W-1:0] quo_in;
      logic [W-1:0] r_reg;
      logic [W-1:0] q_reg;
      logic [W-1:0] d_reg;
      logic         v_reg;

      always_comb begin
         trial  = {rem_ff[s], quo_ff[s][W-1]};
         diff   = trial - {1'b0, dvs_ff[s]};
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[s][W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[s][W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_reg <= 1'b0;
         end else begin
            v_reg <= vld_ff[s];
         end
         r_reg <= rem_in;
         q_reg <= quo_in;
         d_reg <= dvs_ff[s];
      end

      always_comb begin
         rem_ff[s+1] = r_reg;
         quo_ff[s+1] = q_reg;
         dvs_ff[s+1] = d_reg;
         vld_ff[s+1] = v_reg;
      end
   end

   assign out_quotient  = quo_ff[W];
   assign out_remainder = rem_ff[W];

endmodule
